// File: hw/rtl/vrd_pkg.sv
// package for the vector rotation block: fixed-point constants, arctangent table, item type
// depends on nothing; used by every module of the block

package vrd_pkg;

    // default number of cordic cells
    localparam int CORDIC_STAGES_DEF = 24;
    localparam int ATAN_LEN          = 32;

    // angle constants, degrees in q16.16
    localparam logic signed [25:0] TURN_Q16  = 26'sd23592960;
    localparam logic        [24:0] HALF_Q16  = 25'd11796480;
    localparam logic signed [25:0] HALF_Q16S = 26'sd11796480;
    localparam logic signed [25:0] RIGHT_Q16 = 26'sd5898240;

    // a full turn is 45 * 2^19, so the reduction works on angle >> 19 modulo 45
    localparam int             LOW_BITS  = 19;
    localparam logic    [13:0] MOD_BIAS  = 14'd4140;   // 92 * 45, makes the high part positive
    localparam logic    [10:0] RECIP_45  = 11'd1456;   // floor(2^16 / 45), never overestimates
    localparam logic     [6:0] TURN_STEPS = 7'd45;

    // cordic start vector, gain compensated, q1.30
    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;      // residual angle, degrees q.24
        logic signed [31:0] cx;     // cosine, q1.30
        logic signed [31:0] sy;     // sine, q1.30
        logic               flip;   // angle was folded by 180 degrees
    } vrd_item_t;

    // atan(2^-idx) in degrees, q.24
    function automatic logic signed [31:0] atan_q24(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd754974720;
            5'd1:    v = 32'sd445687602;
            5'd2:    v = 32'sd235489088;
            5'd3:    v = 32'sd119537938;
            5'd4:    v = 32'sd60000934;
            5'd5:    v = 32'sd30029717;
            5'd6:    v = 32'sd15018523;
            5'd7:    v = 32'sd7509720;
            5'd8:    v = 32'sd3754917;
            5'd9:    v = 32'sd1877466;
            5'd10:   v = 32'sd938734;
            5'd11:   v = 32'sd469367;
            5'd12:   v = 32'sd234684;
            5'd13:   v = 32'sd117342;
            5'd14:   v = 32'sd58671;
            5'd15:   v = 32'sd29335;
            5'd16:   v = 32'sd14668;
            5'd17:   v = 32'sd7334;
            5'd18:   v = 32'sd3667;
            5'd19:   v = 32'sd1833;
            5'd20:   v = 32'sd917;
            5'd21:   v = 32'sd458;
            5'd22:   v = 32'sd229;
            5'd23:   v = 32'sd115;
            5'd24:   v = 32'sd57;
            5'd25:   v = 32'sd29;
            5'd26:   v = 32'sd14;
            5'd27:   v = 32'sd7;
            5'd28:   v = 32'sd4;
            5'd29:   v = 32'sd2;
            5'd30:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/vrd_reduce.sv
// angle reduction front end: modulo 360, center to [-180, 180), fold to [-90, 90]
// three pipeline registers; depends on vrd_pkg

module vrd_reduce (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  logic signed [31:0]     up_x,
    input  logic signed [31:0]     up_y,
    input  logic signed [31:0]     up_angle,
    output logic                   dn_valid,
    input  logic                   dn_ready,
    output vrd_pkg::vrd_item_t     dn_item
);

    // stage a: high part plus bias, reciprocal quotient estimate
    logic               a_valid_reg;
    logic [13:0]        a_u_reg;
    logic [7:0]         a_q_reg;
    logic [18:0]        a_low_reg;
    logic signed [31:0] a_x_reg;
    logic signed [31:0] a_y_reg;

    // stage b: centered angle
    logic               b_valid_reg;
    logic signed [25:0] b_a_reg;
    logic signed [31:0] b_x_reg;
    logic signed [31:0] b_y_reg;

    // stage c: folded item
    logic               c_valid_reg;
    vrd_pkg::vrd_item_t c_item_reg;

    logic               rdy_a;
    logic               rdy_b;
    logic               rdy_c;

    logic signed [13:0] h_ext;
    logic [13:0]        u_next;
    logic [24:0]        prod;
    logic [13:0]        r_full;
    logic [6:0]         r_raw;
    logic [5:0]         r_mod;
    logic [24:0]        a_mod;
    logic signed [25:0] b_a_next;
    logic signed [25:0] a_fold;
    logic               flip_next;
    vrd_pkg::vrd_item_t c_item_next;

    assign rdy_c    = !c_valid_reg || dn_ready;
    assign rdy_b    = !b_valid_reg || rdy_c;
    assign rdy_a    = !a_valid_reg || rdy_b;
    assign up_ready = rdy_a;
    assign dn_valid = c_valid_reg;
    assign dn_item  = c_item_reg;

    always_comb
    begin
        h_ext  = {up_angle[31], up_angle[31:vrd_pkg::LOW_BITS]};
        u_next = h_ext + vrd_pkg::MOD_BIAS;
        prod   = u_next * vrd_pkg::RECIP_45;
    end

    // remainder is below 90, one correction brings it below 45
    always_comb
    begin
        r_full = a_u_reg - 14'(a_q_reg) * 14'(vrd_pkg::TURN_STEPS);
        r_raw  = r_full[6:0];
        if (r_raw >= vrd_pkg::TURN_STEPS)
        begin
            r_mod = 6'(r_raw - vrd_pkg::TURN_STEPS);
        end
        else
        begin
            r_mod = r_raw[5:0];
        end
        a_mod = {r_mod, a_low_reg};
        if (a_mod >= vrd_pkg::HALF_Q16)
        begin
            b_a_next = $signed({1'b0, a_mod}) - vrd_pkg::TURN_Q16;
        end
        else
        begin
            b_a_next = $signed({1'b0, a_mod});
        end
    end

    always_comb
    begin
        a_fold    = b_a_reg;
        flip_next = 1'b0;
        if (b_a_reg > vrd_pkg::RIGHT_Q16)
        begin
            a_fold    = b_a_reg - vrd_pkg::HALF_Q16S;
            flip_next = 1'b1;
        end
        else if (b_a_reg < -vrd_pkg::RIGHT_Q16)
        begin
            a_fold    = b_a_reg + vrd_pkg::HALF_Q16S;
            flip_next = 1'b1;
        end
        c_item_next.x    = b_x_reg;
        c_item_next.y    = b_y_reg;
        c_item_next.z    = {a_fold[23:0], 8'd0};
        c_item_next.cx   = vrd_pkg::GAIN_Q30;
        c_item_next.sy   = '0;
        c_item_next.flip = flip_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
            begin
                a_valid_reg <= up_valid;
            end
            if (rdy_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (rdy_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && rdy_a)
        begin
            a_u_reg   <= u_next;
            a_q_reg   <= prod[23:16];
            a_low_reg <= up_angle[vrd_pkg::LOW_BITS-1:0];
            a_x_reg   <= up_x;
            a_y_reg   <= up_y;
        end
        if (a_valid_reg && rdy_b)
        begin
            b_a_reg <= b_a_next;
            b_x_reg <= a_x_reg;
            b_y_reg <= a_y_reg;
        end
        if (b_valid_reg && rdy_c)
        begin
            c_item_reg <= c_item_next;
        end
    end

endmodule

// File: hw/rtl/vrd_cordic_cell.sv
// one rotation-mode cordic cell: a micro-rotation by atan(2^-STAGE) and a pipeline register
// depends on vrd_pkg

module vrd_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  vrd_pkg::vrd_item_t up_item,
    output logic               dn_valid,
    input  logic               dn_ready,
    output vrd_pkg::vrd_item_t dn_item
);

    logic               valid_reg;
    vrd_pkg::vrd_item_t item_reg;
    vrd_pkg::vrd_item_t item_next;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] step;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

    always_comb
    begin
        dx        = up_item.sy >>> STAGE;
        dy        = up_item.cx >>> STAGE;
        step      = vrd_pkg::atan_q24(5'(STAGE));
        item_next = up_item;
        if (!up_item.z[31])
        begin
            item_next.cx = up_item.cx - dx;
            item_next.sy = up_item.sy + dy;
            item_next.z  = up_item.z - step;
        end
        else
        begin
            item_next.cx = up_item.cx + dx;
            item_next.sy = up_item.sy - dy;
            item_next.z  = up_item.z + step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// File: hw/rtl/vrd_rotate_out.sv
// back end: undo the 180 degree fold, form the four products, round and saturate
// three pipeline registers, the last one is the output register; depends on vrd_pkg

module vrd_rotate_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  vrd_pkg::vrd_item_t up_item,
    output logic               dn_valid,
    input  logic               dn_ready,
    output logic signed [31:0] dn_x,
    output logic signed [31:0] dn_y
);

    logic               f_valid_reg;
    logic signed [31:0] f_x_reg;
    logic signed [31:0] f_y_reg;
    logic signed [31:0] f_cx_reg;
    logic signed [31:0] f_sy_reg;

    logic               p_valid_reg;
    logic signed [63:0] p_xc_reg;
    logic signed [63:0] p_ys_reg;
    logic signed [63:0] p_xs_reg;
    logic signed [63:0] p_yc_reg;

    logic               s_valid_reg;
    logic signed [31:0] s_x_reg;
    logic signed [31:0] s_y_reg;

    logic               rdy_f;
    logic               rdy_p;
    logic               rdy_s;

    logic signed [63:0] p_xc_next;
    logic signed [63:0] p_ys_next;
    logic signed [63:0] p_xs_next;
    logic signed [63:0] p_yc_next;
    logic signed [64:0] sum_x;
    logic signed [64:0] sum_y;
    logic signed [31:0] s_x_next;
    logic signed [31:0] s_y_next;

    localparam logic signed [64:0] ROUND_HALF = 65'sd536870912;

    // saturate a value that has 35 significant bits to 32
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if ((v[34:31] == 4'b0000) || (v[34:31] == 4'b1111))
        begin
            r = v[31:0];
        end
        else if (v[34])
        begin
            r = {1'b1, 31'd0};
        end
        else
        begin
            r = {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

    assign rdy_s    = !s_valid_reg || dn_ready;
    assign rdy_p    = !p_valid_reg || rdy_s;
    assign rdy_f    = !f_valid_reg || rdy_p;
    assign up_ready = rdy_f;
    assign dn_valid = s_valid_reg;
    assign dn_x     = s_x_reg;
    assign dn_y     = s_y_reg;

    always_comb
    begin
        p_xc_next = f_x_reg * f_cx_reg;
        p_ys_next = f_y_reg * f_sy_reg;
        p_xs_next = f_x_reg * f_sy_reg;
        p_yc_next = f_y_reg * f_cx_reg;
    end

    always_comb
    begin
        sum_x    = 65'(p_xc_reg) - 65'(p_ys_reg) + ROUND_HALF;
        sum_y    = 65'(p_xs_reg) + 65'(p_yc_reg) + ROUND_HALF;
        s_x_next = sat32(sum_x[64:30]);
        s_y_next = sat32(sum_y[64:30]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy_f)
            begin
                f_valid_reg <= up_valid;
            end
            if (rdy_p)
            begin
                p_valid_reg <= f_valid_reg;
            end
            if (rdy_s)
            begin
                s_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && rdy_f)
        begin
            f_x_reg  <= up_item.x;
            f_y_reg  <= up_item.y;
            f_cx_reg <= up_item.flip ? -up_item.cx : up_item.cx;
            f_sy_reg <= up_item.flip ? -up_item.sy : up_item.sy;
        end
        if (f_valid_reg && rdy_p)
        begin
            p_xc_reg <= p_xc_next;
            p_ys_reg <= p_ys_next;
            p_xs_reg <= p_xs_next;
            p_yc_reg <= p_yc_next;
        end
        if (p_valid_reg && rdy_s)
        begin
            s_x_reg <= s_x_next;
            s_y_reg <= s_y_next;
        end
    end

endmodule

// File: hw/rtl/vector_rotate_degrees.sv
// top level of the vector rotation block: reduction front end, cordic cell chain, product back end
// depends on vrd_pkg, vrd_reduce, vrd_cordic_cell and vrd_rotate_out
//
// rotates a signed q16.16 vector (in_x, in_y) counter-clockwise by angle_deg, a signed q16.16
// angle in degrees, and returns the rotated vector (out_x, out_y) in q16.16, saturated to the
// 32-bit limits. the angle is reduced modulo 360 and folded into [-90, 90] degrees; cosine and
// sine come from a row of CORDIC_STAGES rotation-mode cordic cells started on a gain-compensated
// vector, and the rotation products are rounded half up. every stage is one register and each
// stage holds its own item, so while out_stall is low a new transfer is taken in every cycle and
// the block delivers one rotated vector per cycle. from input transfer to output valid an item
// passes the angle reduction registers, one register per cordic cell, and the back-end registers
// (fold undo, the four 32 x 32 products, round and saturate). a stage moves on when it is empty
// or the stage after it moves, so a stalled output only holds back the items behind it and
// empty slots in the chain keep filling. there is no state between items and no configuration.

module vector_rotate_degrees #(
    parameter int CORDIC_STAGES = vrd_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [31:0] angle_deg,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y
);

    // chain links: link 0 leaves the front end, link CORDIC_STAGES enters the back end
    logic               link_valid [CORDIC_STAGES+1];
    logic               link_ready [CORDIC_STAGES+1];
    vrd_pkg::vrd_item_t link_item  [CORDIC_STAGES+1];

    logic               front_ready;

    assign in_stall = !front_ready;

    vrd_reduce u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (front_ready),
        .up_x     (in_x),
        .up_y     (in_y),
        .up_angle (angle_deg),
        .dn_valid (link_valid[0]),
        .dn_ready (link_ready[0]),
        .dn_item  (link_item[0])
    );

    // one cell per cordic iteration, each hands its item to the next once that one is ready
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        vrd_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[i]),
            .up_ready (link_ready[i]),
            .up_item  (link_item[i]),
            .dn_valid (link_valid[i+1]),
            .dn_ready (link_ready[i+1]),
            .dn_item  (link_item[i+1])
        );
    end

    // back end owns the output register
    vrd_rotate_out u_rotate_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (link_valid[CORDIC_STAGES]),
        .up_ready (link_ready[CORDIC_STAGES]),
        .up_item  (link_item[CORDIC_STAGES]),
        .dn_valid (out_valid),
        .dn_ready (!out_stall),
        .dn_x     (out_x),
        .dn_y     (out_y)
    );

endmodule

// File: test/vrd_checker.sv
`timescale 1ns / 100ps
// checker for the vector rotation block: watches both channels, predicts each rotated vector
// and compares it field by field; depends on vrd_pkg for the default stage count

module vrd_checker #(
    parameter int STAGES = vrd_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [31:0] angle_deg,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] out_x,
    input  logic signed [31:0] out_y,
    output int                 mismatches,
    output int                 outstanding
);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } vec_t;

    localparam longint FULL_TURN  = 64'sd23592960;
    localparam longint HALF_TURN  = 64'sd11796480;
    localparam longint QUARTER    = 64'sd5898240;
    localparam longint START_GAIN = 64'sd652032874;

    vec_t   rotations_due[$];
    longint atan_deg[32];

    initial
    begin
        atan_deg = '{754974720, 445687602, 235489088, 119537938,
                     60000934, 30029717, 15018523, 7509720,
                     3754917, 1877466, 938734, 469367,
                     234684, 117342, 58671, 29335,
                     14668, 7334, 3667, 1833,
                     917, 458, 229, 115,
                     57, 29, 14, 7,
                     4, 2, 1, 0};
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic logic signed [31:0] clamp_q16(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic vec_t rotate_vector(input logic signed [31:0] vx,
                                           input logic signed [31:0] vy,
                                           input logic signed [31:0] ang);
        longint a;
        longint z;
        longint c;
        longint s;
        longint dc;
        longint ds;
        longint half_lsb;
        bit     flip;
        vec_t   r;
        // floor modulus into [-180, 180), then fold into [-90, 90]
        a = longint'(ang) % FULL_TURN;
        if (a < 0)
            a += FULL_TURN;
        if (a >= HALF_TURN)
            a -= FULL_TURN;
        flip = 1'b0;
        if (a > QUARTER)
        begin
            a -= HALF_TURN;
            flip = 1'b1;
        end
        else if (a < -QUARTER)
        begin
            a += HALF_TURN;
            flip = 1'b1;
        end
        z = a * 256;
        c = START_GAIN;
        s = 0;
        for (int i = 0; i < STAGES && i < 32; i++)
        begin
            ds = s >>> i;
            dc = c >>> i;
            if (z >= 0)
            begin
                c -= ds;
                s += dc;
                z -= atan_deg[i];
            end
            else
            begin
                c += ds;
                s -= dc;
                z += atan_deg[i];
            end
        end
        if (flip)
        begin
            c = -c;
            s = -s;
        end
        half_lsb = longint'(1) <<< 29;
        r.x = clamp_q16((longint'(vx) * c - longint'(vy) * s + half_lsb) >>> 30);
        r.y = clamp_q16((longint'(vx) * s + longint'(vy) * c + half_lsb) >>> 30);
        return r;
    endfunction

    always @(posedge clk)
    begin
        vec_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                rotations_due.push_back(rotate_vector(in_x, in_y, angle_deg));
            if (out_valid && !out_stall)
            begin
                if (rotations_due.size() == 0)
                begin
                    $error("result transfer with no rotation pending: out_x %0d out_y %0d",
                           out_x, out_y);
                    mismatches++;
                end
                else
                begin
                    want = rotations_due.pop_front();
                    if (out_x !== want.x)
                    begin
                        $error("out_x: expected %0d, actual %0d", want.x, out_x);
                        mismatches++;
                    end
                    if (out_y !== want.y)
                    begin
                        $error("out_y: expected %0d, actual %0d", want.y, out_y);
                        mismatches++;
                    end
                end
            end
        end
        outstanding <= rotations_due.size();
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// top of the vector rotation testbench: clock, reset, stimulus, output stall and verdict
// depends on vrd_pkg, vector_rotate_degrees and vrd_checker

module tb_top;

    localparam int STAGES     = vrd_pkg::CORDIC_STAGES_DEF;
    localparam int N_RANDOM   = 400;
    localparam int IDLE_LIMIT = 2000;   // cycles with no transfer on either side

    // handy q16.16 values
    localparam logic signed [31:0] ONE   = 32'sd65536;
    localparam logic signed [31:0] DEG45 = 32'sd2949120;
    localparam logic signed [31:0] DEG90 = 32'sd5898240;
    localparam logic signed [31:0] DEG180 = 32'sd11796480;
    localparam logic signed [31:0] DEG270 = 32'sd17694720;
    localparam logic signed [31:0] DEG360 = 32'sd23592960;
    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] angle_deg;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;

    int  mismatches;
    int  outstanding;
    int  quiet_cycles;
    bit  no_idle;       // when set both sides run back to back

    wire in_xfer  = in_valid && !in_stall;
    wire out_xfer = out_valid && !out_stall;

    vector_rotate_degrees #(
        .CORDIC_STAGES (STAGES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_x      (in_x),
        .in_y      (in_y),
        .angle_deg (angle_deg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y)
    );

    vrd_checker #(
        .STAGES (STAGES)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_x        (in_x),
        .in_y        (in_y),
        .angle_deg   (angle_deg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_x       (out_x),
        .out_y       (out_y),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
        clk = 1'b0;

    always #2 clk = ~clk;

    // cycles a side waits before its next transfer
    function automatic int draw_idle();
        if (no_idle)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    // one input transfer: idle gap, then hold the vector until it is taken
    task automatic send_vector(input logic signed [31:0] vx,
                               input logic signed [31:0] vy,
                               input logic signed [31:0] ang);
        int gap;
        gap = draw_idle();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid  = 1'b1;
        in_x      = vx;
        in_y      = vy;
        angle_deg = ang;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // drop valid and let every pending rotation come out
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // watchdog: any transfer on either side resets the count
    always @(posedge clk)
    begin
        if (!rst_n || in_xfer || out_xfer)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiving side: random stall before each result transfer
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = draw_idle();
            repeat (hold)
            begin
                @(negedge clk);
                out_stall = 1'b1;
            end
            @(negedge clk);
            out_stall = 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // stimulus and verdict
    initial
    begin
        int                 kind;
        int                 k;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] ra;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_x         = '0;
        in_y         = '0;
        angle_deg    = '0;
        no_idle      = 1'b0;
        quiet_cycles = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero vector, quadrant angles, wraps, folds and saturation
        send_vector('0, '0, '0);
        send_vector(ONE, '0, '0);
        send_vector(ONE, '0, DEG45);
        send_vector(ONE, '0, DEG90);
        send_vector(ONE, '0, -DEG90);
        send_vector(ONE, ONE, DEG90 + 1);       // just past a right angle, folds
        send_vector(ONE, ONE, -DEG90 - 1);      // just below minus a right angle
        send_vector(ONE, '0, DEG180);           // wraps to minus half a turn
        send_vector(ONE, '0, -DEG180);
        send_vector(ONE, ONE, DEG270);
        send_vector(ONE, ONE, DEG360);          // full turn reduces to zero
        send_vector(ONE, ONE, -DEG360);
        send_vector(ONE, ONE, DEG360 - 1);
        send_vector(ONE, -ONE, Q_MAX);          // extreme angles
        send_vector(-ONE, ONE, Q_MIN);
        send_vector(Q_MAX, Q_MAX, DEG45);       // out_y overflows high
        send_vector(Q_MIN, Q_MIN, DEG45);       // out_y overflows low
        send_vector(Q_MAX, Q_MIN, -DEG45);
        send_vector(Q_MIN, Q_MAX, DEG180);      // negating the minimum saturates
        send_vector(Q_MAX, Q_MIN, '0);
        send_vector(32'sd1, -32'sd1, DEG45);    // smallest values, rounding
        send_vector(Q_MIN, '0, DEG90);

        // sender holds off until the directed results have all come back
        drain_results();

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // switch between idling and back-to-back stretches
            if (n % 40 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            if (n == N_RANDOM / 2)
                drain_results();
            kind = $urandom_range(0, 9);
            if (kind <= 3)
            begin
                // full range on every field
                rx = $urandom;
                ry = $urandom;
                ra = $urandom;
            end
            else if (kind <= 6)
            begin
                // moderate vectors, angles within two turns
                rx = int'($urandom_range(0, 2097152)) - 1048576;
                ry = int'($urandom_range(0, 2097152)) - 1048576;
                ra = int'($urandom_range(0, 94371840)) - 47185920;
            end
            else if (kind == 7)
            begin
                // near multiples of a right angle, where folds and wraps switch
                k  = int'($urandom_range(0, 16)) - 8;
                rx = int'($urandom_range(0, 16777216)) - 8388608;
                ry = int'($urandom_range(0, 16777216)) - 8388608;
                ra = k * DEG90 + int'($urandom_range(0, 4)) - 2;
            end
            else if (kind == 8)
            begin
                // large magnitudes to reach saturation
                rx = $urandom;
                ry = $urandom;
                rx[30:26] = {5{~rx[31]}};
                ry[30:26] = {5{~ry[31]}};
                ra = int'($urandom_range(0, 47185920)) - 23592960;
            end
            else
            begin
                // many turns added to a small angle
                k  = int'($urandom_range(0, 180)) - 90;
                rx = int'($urandom_range(0, 655360)) - 327680;
                ry = int'($urandom_range(0, 655360)) - 327680;
                ra = k * DEG360 + int'($urandom_range(0, 47185920)) - 23592960;
            end
            send_vector(rx, ry, ra);
        end

        drain_results();
        repeat (STAGES + 12) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
